@@ hdl/pneumatic_valve_pulse_sequencer_unit_macros.svh @@
// assertion macros for the pneumatic valve pulse sequencer
`ifndef PNEUMATIC_VALVE_PULSE_SEQUENCER_UNIT_MACROS_SVH
`define PNEUMATIC_VALVE_PULSE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define PVPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvps assertion failed");

// next-cycle implication, reset masked
`define PVPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pvps assertion failed");

`endif

@@ hdl/pvps_pkg.sv @@
// shared types and constants of the pneumatic valve pulse sequencer
`timescale 1ns / 1ps
package pvps_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int DIV_STEPS     = FIELD_W;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  localparam logic [FIELD_W-1:0] PULSE_OPEN_RST  = 16'd100;
  localparam logic [FIELD_W-1:0] SHORT_LIMIT_RST = 16'd50;
  localparam logic [FIELD_W-1:0] SEAL_RST        = 16'd50;
  localparam logic [FIELD_W-1:0] DRAIN_DIVISOR   = 16'd5;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_PRESS   = 2'd1,
    FN_RELEASE = 2'd2,
    FN_CANCEL  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SEAL        = 3'd1,
    PH_SHORT_OPEN  = 3'd2,
    PH_SHORT_WAIT  = 3'd3,
    PH_LOOP_OPEN   = 3'd4,
    PH_LOOP_CLOSED = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CFG_PULSE_OPEN  = 2'd0,
    CFG_SHORT_LIMIT = 2'd1,
    CFG_SEAL        = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_DIV  = 2'd1,
    CS_FIN  = 2'd2,
    CS_PUSH = 2'd3
  } ctl_state_e;

  typedef struct packed {
    logic tick;
    logic cancel;
    logic start_load;
    op_e  start_op;
    logic div_step;
    logic start_commit;
    logic snap_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

@@ hdl/pvps_ctrl.sv @@
// controller state machine: handshakes and sequencing of the datapath
`timescale 1ns / 1ps
module pvps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pvps_pkg::cmd_t  cmd_o,
  input  pvps_pkg::sts_t  sts_i
);
  import pvps_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != CS_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == CS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.start_op = OP_PRESS;
    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FN_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = CS_PUSH;
            end
            FN_CANCEL: begin
              cmd_o.cancel = 1'b1;
              state_d      = CS_PUSH;
            end
            FN_PRESS, FN_RELEASE: begin
              cmd_o.start_load = 1'b1;
              cmd_o.start_op   = (func_e'(func_i) == FN_PRESS) ? OP_PRESS : OP_RELEASE;
              state_d          = CS_DIV;
            end
            default: state_d = CS_IDLE;
          endcase
        end
      end
      CS_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = CS_FIN;
        end
      end
      CS_FIN: begin
        cmd_o.start_commit = 1'b1;
        state_d            = CS_PUSH;
      end
      CS_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.snap_load = 1'b1;
          state_d         = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.snap_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

@@ hdl/pvps_datapath.sv @@
// datapath: valve state, elapsed counter, serial divider, config and result registers
`timescale 1ns / 1ps
module pvps_datapath #(
  parameter int TIME_BITS = pvps_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvps_pkg::cmd_t                cmd_i,
  output pvps_pkg::sts_t                sts_o,
  input  logic [pvps_pkg::FIELD_W-1:0]  pressure_ms_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [pvps_pkg::FIELD_W-1:0]  cfg_data_i,
  output logic                          inlet_open_o,
  output logic                          outlet_open_o,
  output logic                          busy_res_o,
  output logic [2:0]                    phase_now_o,
  output logic [1:0]                    operation_now_o
);
  import pvps_pkg::*;

  localparam int LIM_W = FIELD_W + 1;
  localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;
  localparam logic [TIME_BITS-1:0] ELAPSED_MAX = {TIME_BITS{1'b1}};

  // configuration
  logic [FIELD_W-1:0] po_q, sl_q, seal_q;

  // sequencer state
  phase_e             phase_q, phase_d;
  op_e                op_q, op_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d, elapsed_n;
  logic [FIELD_W-1:0] pulses_q, pulses_d;
  logic [LIM_W-1:0]   drain_q, drain_d, target_q, target_d;
  logic [FIELD_W-1:0] req_q, req_d;
  logic               drain_mode_q, drain_mode_d;
  logic               inlet_q, inlet_d, outlet_q, outlet_d;

  // pending start and divider
  op_e                st_op_q, st_op_d;
  logic [FIELD_W-1:0] st_t_q, st_t_d;
  logic [FIELD_W-1:0] dvd_q, dvd_d, dvs_q, dvs_d;
  logic [FIELD_W-1:0] rem_q, rem_d;
  logic [FIELD_W:0]   rem_sh;
  logic               rem_ge;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // result snapshot
  logic   snap_inlet_q, snap_outlet_q;
  phase_e snap_phase_q;
  op_e    snap_op_q;

  logic [LIM_W-1:0] limit;
  logic             waited;
  logic             main_inlet;

  assign sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  assign inlet_open_o    = snap_inlet_q;
  assign outlet_open_o   = snap_outlet_q;
  assign busy_res_o      = (snap_op_q != OP_NONE);
  assign phase_now_o     = snap_phase_q;
  assign operation_now_o = snap_op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      po_q   <= PULSE_OPEN_RST;
      sl_q   <= SHORT_LIMIT_RST;
      seal_q <= SEAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PULSE_OPEN:  po_q   <= cfg_data_i;
        CFG_SHORT_LIMIT: sl_q   <= cfg_data_i;
        CFG_SEAL:        seal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, dvd_q[FIELD_W-1]};
    rem_ge = (rem_sh >= {1'b0, dvs_q});
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    st_op_d = st_op_q;
    st_t_d  = st_t_q;
    if (cmd_i.start_load) begin
      st_op_d = cmd_i.start_op;
      st_t_d  = pressure_ms_i;
      dvd_d   = pressure_ms_i;
      dvs_d   = (pressure_ms_i < po_q) ? DRAIN_DIVISOR : po_q;
      rem_d   = '0;
      cnt_d   = '0;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? FIELD_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[FIELD_W-1:0];
      dvd_d = {dvd_q[FIELD_W-2:0], rem_ge};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_op_q <= OP_NONE;
      cnt_q   <= '0;
    end else begin
      st_op_q <= st_op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_t_q <= st_t_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
  end

  // wait test of the current phase
  always_comb begin
    elapsed_n = (elapsed_q == ELAPSED_MAX) ? elapsed_q : (elapsed_q + TIME_BITS'(1));
    unique case (phase_q)
      PH_SEAL, PH_LOOP_CLOSED: limit = LIM_W'(seal_q);
      PH_SHORT_OPEN:           limit = drain_mode_q ? drain_q : target_q;
      PH_SHORT_WAIT:           limit = target_q;
      PH_LOOP_OPEN:            limit = LIM_W'(po_q);
      default:                 limit = '0;
    endcase
    waited = (CMP_W'(elapsed_n) >= CMP_W'(limit)) || (elapsed_n == ELAPSED_MAX);
  end

  always_comb begin
    phase_d      = phase_q;
    op_d         = op_q;
    elapsed_d    = elapsed_q;
    pulses_d     = pulses_q;
    drain_d      = drain_q;
    target_d     = target_q;
    req_d        = req_q;
    drain_mode_d = drain_mode_q;
    inlet_d      = inlet_q;
    outlet_d     = outlet_q;
    main_inlet   = (op_q == OP_PRESS);

    if (cmd_i.cancel) begin
      inlet_d   = 1'b0;
      outlet_d  = 1'b0;
      op_d      = OP_NONE;
      phase_d   = PH_IDLE;
      elapsed_d = '0;
    end else if (cmd_i.tick && (op_q != OP_NONE)) begin
      elapsed_d = elapsed_n;
      case (phase_q)
        PH_SEAL: begin
          if (waited) begin
            if (main_inlet) inlet_d = 1'b1;
            else outlet_d = 1'b1;
            elapsed_d = '0;
            if (req_q < po_q) begin
              if (drain_mode_q) begin
                if (main_inlet) outlet_d = 1'b1;
                else inlet_d = 1'b1;
              end
              phase_d = PH_SHORT_OPEN;
            end else begin
              phase_d = PH_LOOP_OPEN;
            end
          end
        end
        PH_SHORT_OPEN: begin
          if (waited) begin
            elapsed_d = '0;
            if (drain_mode_q) begin
              if (main_inlet) outlet_d = 1'b0;
              else inlet_d = 1'b0;
              phase_d = PH_SHORT_WAIT;
            end else begin
              if (main_inlet) inlet_d = 1'b0;
              else outlet_d = 1'b0;
              op_d    = OP_NONE;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_SHORT_WAIT: begin
          if (waited) begin
            if (main_inlet) inlet_d = 1'b0;
            else outlet_d = 1'b0;
            op_d      = OP_NONE;
            phase_d   = PH_IDLE;
            elapsed_d = '0;
          end
        end
        PH_LOOP_OPEN: begin
          if (waited) begin
            if (main_inlet) inlet_d = 1'b0;
            else outlet_d = 1'b0;
            elapsed_d = '0;
            if (pulses_q <= FIELD_W'(1)) begin
              pulses_d = '0;
              op_d     = OP_NONE;
              phase_d  = PH_IDLE;
            end else begin
              pulses_d = pulses_q - FIELD_W'(1);
              phase_d  = PH_LOOP_CLOSED;
            end
          end
        end
        PH_LOOP_CLOSED: begin
          if (waited) begin
            if (main_inlet) inlet_d = 1'b1;
            else outlet_d = 1'b1;
            phase_d   = PH_LOOP_OPEN;
            elapsed_d = '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.start_commit) begin
      req_d = st_t_q;
      if (st_t_q < po_q) begin
        if (st_t_q < sl_q) begin
          drain_mode_d = 1'b1;
          drain_d      = LIM_W'(po_q) + LIM_W'(dvd_q);
          target_d     = LIM_W'(st_t_q);
        end else begin
          drain_mode_d = 1'b0;
          target_d     = LIM_W'(st_t_q) + LIM_W'(po_q);
        end
        pulses_d = '0;
      end else begin
        drain_mode_d = 1'b0;
        pulses_d     = dvd_q;
        target_d     = LIM_W'(st_t_q);
      end
      op_d = st_op_q;
      if (st_op_q == OP_PRESS) outlet_d = 1'b0;
      else inlet_d = 1'b0;
      phase_d   = PH_SEAL;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      op_q         <= OP_NONE;
      elapsed_q    <= '0;
      pulses_q     <= '0;
      drain_q      <= '0;
      target_q     <= '0;
      req_q        <= '0;
      drain_mode_q <= 1'b0;
      inlet_q      <= 1'b0;
      outlet_q     <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      op_q         <= op_d;
      elapsed_q    <= elapsed_d;
      pulses_q     <= pulses_d;
      drain_q      <= drain_d;
      target_q     <= target_d;
      req_q        <= req_d;
      drain_mode_q <= drain_mode_d;
      inlet_q      <= inlet_d;
      outlet_q     <= outlet_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap_load) begin
      snap_inlet_q  <= inlet_q;
      snap_outlet_q <= outlet_q;
      snap_phase_q  <= phase_q;
      snap_op_q     <= op_q;
    end
  end

endmodule

@@ hdl/pneumatic_valve_pulse_sequencer_unit.sv @@
// top level of the pneumatic valve pulse sequencer
`timescale 1ns / 1ps
// Valve pulse sequencer for one pneumatic muscle. Each item is a millisecond
// tick, a pressurize or depressurize start, or a cancel, and gives one result
// item with the valve commands, busy flag, phase and operation after it. A tick
// or cancel goes through the push state to the result register, and a start
// through the divide, finish and push states; the input is stalled until the
// result is loaded. The 16-step serial divider works out the pulse count
// (or time/5 for short requests). The next item is accepted as soon as the
// result is in the output register, even while that result is stalled.
// Configuration writes are always ready and are meant for idle periods.
module pneumatic_valve_pulse_sequencer_unit #(
  parameter int TIME_BITS = pvps_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [pvps_pkg::FIELD_W-1:0]  pressure_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inlet_open_o,
  output logic                          outlet_open_o,
  output logic                          busy_res_o,
  output logic [2:0]                    phase_now_o,
  output logic [1:0]                    operation_now_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [pvps_pkg::FIELD_W-1:0]  cfg_data_i
);
  import pvps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pvps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pvps_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pressure_ms_i   (pressure_ms_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .inlet_open_o    (inlet_open_o),
    .outlet_open_o   (outlet_open_o),
    .busy_res_o      (busy_res_o),
    .phase_now_o     (phase_now_o),
    .operation_now_o (operation_now_o)
  );

endmodule

@@ hdl/pvps_checker.sv @@
// port-level checker for the pneumatic valve pulse sequencer, with its bind
`timescale 1ns / 1ps
`include "pneumatic_valve_pulse_sequencer_unit_macros.svh"
module pvps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          inlet_open_o,
  input logic                          outlet_open_o,
  input logic                          busy_res_o,
  input logic [2:0]                    phase_now_o,
  input logic [1:0]                    operation_now_o
);
  import pvps_pkg::*;

  logic [7:0] res_bits;
  logic       idle_res;

  assign res_bits = {inlet_open_o, outlet_open_o, busy_res_o, phase_now_o, operation_now_o};
  assign idle_res = out_valid_o && (operation_now_o == OP_NONE);

  // stalled result holds
  `PVPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(res_bits))

  // busy flag follows the operation
  `PVPS_ASSERT_NOW(a_busy_op, clk_i, rst_ni, out_valid_o, busy_res_o == (operation_now_o != OP_NONE))

  // no operation means idle phase
  `PVPS_ASSERT_NOW(a_idle_phase, clk_i, rst_ni, idle_res, phase_now_o == PH_IDLE)

  // inlet always closed once idle
  `PVPS_ASSERT_NOW(a_idle_inlet, clk_i, rst_ni, idle_res, !inlet_open_o)

endmodule

bind pneumatic_valve_pulse_sequencer_unit pvps_checker u_pvps_checker (.*);
